// File: hdl/tcp_pkg.sv
package tcp_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		REG_VTX_A   = 3'd0,
		REG_VTX_B   = 3'd1,
		REG_EDGE_AB = 3'd2,
		REG_VTX_C   = 3'd3,
		REG_EDGE_AC = 3'd4,
		REG_EDGE_BC = 3'd5,
		REG_FACE    = 3'd6
	} region_t;

	typedef enum logic [1:0] {
		SEL_A = 2'd0,
		SEL_B = 2'd1,
		SEL_C = 2'd2
	} vsel_t;

endpackage

// File: hdl/triangle_closest_point.sv
// Channel | Direction | Handshake             | Beat contents
// in      | input     | in_valid / in_ready   | vertex_a/b/c_x/y/z, query_x/y/z
// out     | output    | out_valid / out_ready | nearest_x/y/z, region, degenerate
//
// One beat is accepted every cycle while the output beat is not held. The pipeline has nine
// arithmetic stages including the divider entry, one restoring divider stage per quotient bit,
// and an output stage. The quotient width, COORD_WIDTH + 8 bits, sets the depth of the divider.
// Reset clears only the valid bits of the stages.
// When the output beat is held, the whole pipeline holds; nothing is dropped or repeated.
module triangle_closest_point
	import tcp_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
	input  logic signed [COORD_WIDTH-1:0] query_x,
	input  logic signed [COORD_WIDTH-1:0] query_y,
	input  logic signed [COORD_WIDTH-1:0] query_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] nearest_x,
	output logic signed [COORD_WIDTH-1:0] nearest_y,
	output logic signed [COORD_WIDTH-1:0] nearest_z,
	output logic [2:0]                    region,
	output logic                          degenerate
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * DW;
	localparam int DOTW = PW + 2;
	localparam int VPW  = 2 * DOTW;
	localparam int VW   = VPW + 1;
	localparam int DENW = VW + 2;
	localparam int MW   = VW + DW;
	localparam int NUMW = MW + 1;
	localparam int NW   = NUMW + 2;
	localparam int D2W  = DENW + 1;
	localparam int QW   = W + 8;
	localparam int RW   = D2W + 1;
	localparam int SW   = QW + 3;
	localparam int HW   = DOTW / 2;
	localparam int PPW  = 2 * (HW + 1);
	localparam int CK   = (VW + 3) / 4;
	localparam int TW   = VW - 3 * CK;
	localparam int MPW  = CK + 1 + DW;

	// Operand indexes of the six cross terms, three bits per term, term 0 lowest.
	localparam logic [17:0] OPX = {3'd4, 3'd2, 3'd0, 3'd4, 3'd2, 3'd0};
	localparam logic [17:0] OPY = {3'd3, 3'd5, 3'd5, 3'd1, 3'd1, 3'd3};

	function automatic logic signed [PPW-1:0] smul(input logic signed [HW:0] x,
			input logic signed [HW:0] y);
		return PPW'(x) * PPW'(y);
	endfunction

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: differences
	logic signed [W-1:0]  a_in [3], b_in [3], c_in [3], p_in [3];
	logic signed [W-1:0]  a_s1 [3], b_s1 [3], c_s1 [3];
	logic signed [DW-1:0] ab_s1 [3], ac_s1 [3], bc_s1 [3], ap_s1 [3], bp_s1 [3], cp_s1 [3];
	logic                 vld_s1;

	assign a_in = '{vertex_a_x, vertex_a_y, vertex_a_z};
	assign b_in = '{vertex_b_x, vertex_b_y, vertex_b_z};
	assign c_in = '{vertex_c_x, vertex_c_y, vertex_c_z};
	assign p_in = '{query_x, query_y, query_z};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				a_s1[j]  <= a_in[j];
				b_s1[j]  <= b_in[j];
				c_s1[j]  <= c_in[j];
				ab_s1[j] <= DW'(b_in[j]) - DW'(a_in[j]);
				ac_s1[j] <= DW'(c_in[j]) - DW'(a_in[j]);
				bc_s1[j] <= DW'(c_in[j]) - DW'(b_in[j]);
				ap_s1[j] <= DW'(p_in[j]) - DW'(a_in[j]);
				bp_s1[j] <= DW'(p_in[j]) - DW'(b_in[j]);
				cp_s1[j] <= DW'(p_in[j]) - DW'(c_in[j]);
			end
		end
	end

	// ---------------- stage 2: component products
	logic signed [PW-1:0] pr_s2 [6][3];
	logic signed [W-1:0]  a_s2 [3], b_s2 [3], c_s2 [3];
	logic signed [DW-1:0] ab_s2 [3], ac_s2 [3], bc_s2 [3];
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				pr_s2[0][j] <= PW'(ab_s1[j]) * PW'(ap_s1[j]);
				pr_s2[1][j] <= PW'(ac_s1[j]) * PW'(ap_s1[j]);
				pr_s2[2][j] <= PW'(ab_s1[j]) * PW'(bp_s1[j]);
				pr_s2[3][j] <= PW'(ac_s1[j]) * PW'(bp_s1[j]);
				pr_s2[4][j] <= PW'(ab_s1[j]) * PW'(cp_s1[j]);
				pr_s2[5][j] <= PW'(ac_s1[j]) * PW'(cp_s1[j]);
			end
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			ab_s2 <= ab_s1;
			ac_s2 <= ac_s1;
			bc_s2 <= bc_s1;
		end
	end

	// ---------------- stage 3: dot products d1..d6
	logic signed [DOTW-1:0] d_s3 [6];
	logic signed [W-1:0]    a_s3 [3], b_s3 [3], c_s3 [3];
	logic signed [DW-1:0]   ab_s3 [3], ac_s3 [3], bc_s3 [3];
	logic                   vld_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				d_s3[i] <= DOTW'(pr_s2[i][0]) + DOTW'(pr_s2[i][1]) + DOTW'(pr_s2[i][2]);
			end
			a_s3  <= a_s2;
			b_s3  <= b_s2;
			c_s3  <= c_s2;
			ab_s3 <= ab_s2;
			ac_s3 <= ac_s2;
			bc_s3 <= bc_s2;
		end
	end

	// ---------------- stage 4: partial products of the cross terms
	// Each dot product splits into a signed upper half and an unsigned lower half,
	// so every multiplier stays close to the width of one coordinate.
	logic signed [HW:0]     dh [6], dl [6];
	logic signed [PPW-1:0]  pp_s4 [6][4];
	logic signed [DOTW-1:0] d_s4 [6];
	logic signed [W-1:0]    a_s4 [3], b_s4 [3], c_s4 [3];
	logic signed [DW-1:0]   ab_s4 [3], ac_s4 [3], bc_s4 [3];
	logic                   vld_s4;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			dh[i] = {d_s3[i][DOTW-1], d_s3[i][DOTW-1:HW]};
			dl[i] = {1'b0, d_s3[i][HW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				pp_s4[i][0] <= smul(dh[OPX[3*i +: 3]], dh[OPY[3*i +: 3]]);
				pp_s4[i][1] <= smul(dh[OPX[3*i +: 3]], dl[OPY[3*i +: 3]]);
				pp_s4[i][2] <= smul(dl[OPX[3*i +: 3]], dh[OPY[3*i +: 3]]);
				pp_s4[i][3] <= smul(dl[OPX[3*i +: 3]], dl[OPY[3*i +: 3]]);
			end
			d_s4  <= d_s3;
			a_s4  <= a_s3;
			b_s4  <= b_s3;
			c_s4  <= c_s3;
			ab_s4 <= ab_s3;
			ac_s4 <= ac_s3;
			bc_s4 <= bc_s3;
		end
	end

	// ---------------- stage 5: cross terms of the barycentric weights
	logic signed [VW-1:0]   vp [6];
	logic signed [VW-1:0]   va_s5, vb_s5, vc_s5;
	logic signed [DOTW-1:0] d_s5 [6];
	logic signed [W-1:0]    a_s5 [3], b_s5 [3], c_s5 [3];
	logic signed [DW-1:0]   ab_s5 [3], ac_s5 [3], bc_s5 [3];
	logic                   vld_s5;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			vp[i] = (VW'(pp_s4[i][0]) <<< (2 * HW))
				+ ((VW'(pp_s4[i][1]) + VW'(pp_s4[i][2])) <<< HW)
				+ VW'(pp_s4[i][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vc_s5 <= vp[0] - vp[1];
			vb_s5 <= vp[2] - vp[3];
			va_s5 <= vp[4] - vp[5];
			d_s5  <= d_s4;
			a_s5  <= a_s4;
			b_s5  <= b_s4;
			c_s5  <= c_s4;
			ab_s5 <= ab_s4;
			ac_s5 <= ac_s4;
			bc_s5 <= bc_s4;
		end
	end

	// ---------------- stage 6: region decision
	logic signed [DOTW:0]     e43, e56;
	logic signed [DENW-1:0]   den_c;
	logic signed [VW-1:0]     n1_c, n2_c;
	region_t                  reg_c;
	vsel_t                    base_sel, dir_sel;
	logic                     is_face;
	logic                     le0_d1, le0_d2, le0_d3, le0_d6, le0_e43, le0_e56;

	assign e43 = (DOTW+1)'(d_s5[3]) - (DOTW+1)'(d_s5[2]);
	assign e56 = (DOTW+1)'(d_s5[4]) - (DOTW+1)'(d_s5[5]);
	assign le0_d1  = d_s5[0][DOTW-1] || (d_s5[0] == '0);
	assign le0_d2  = d_s5[1][DOTW-1] || (d_s5[1] == '0);
	assign le0_d3  = d_s5[2][DOTW-1] || (d_s5[2] == '0);
	assign le0_d6  = d_s5[5][DOTW-1] || (d_s5[5] == '0);
	assign le0_e43 = e43[DOTW] || (e43 == '0);
	assign le0_e56 = e56[DOTW] || (e56 == '0);

	always_comb begin
		reg_c    = REG_FACE;
		base_sel = SEL_A;
		dir_sel  = SEL_A;
		n1_c     = '0;
		n2_c     = '0;
		den_c    = '0;
		is_face  = 1'b0;
		priority if (le0_d1 && le0_d2) begin
			reg_c = REG_VTX_A;
		end else if (!d_s5[2][DOTW-1] && le0_e43) begin
			reg_c    = REG_VTX_B;
			base_sel = SEL_B;
		end else if ((vc_s5[VW-1] || vc_s5 == '0) && !d_s5[0][DOTW-1] && le0_d3) begin
			reg_c = REG_EDGE_AB;
			n1_c  = VW'(d_s5[0]);
			den_c = DENW'(d_s5[0]) - DENW'(d_s5[2]);
		end else if (!d_s5[5][DOTW-1] && le0_e56) begin
			reg_c    = REG_VTX_C;
			base_sel = SEL_C;
		end else if ((vb_s5[VW-1] || vb_s5 == '0) && !d_s5[1][DOTW-1] && le0_d6) begin
			reg_c   = REG_EDGE_AC;
			dir_sel = SEL_C;
			n1_c    = VW'(d_s5[1]);
			den_c   = DENW'(d_s5[1]) - DENW'(d_s5[5]);
		end else if ((va_s5[VW-1] || va_s5 == '0) && !e43[DOTW] && !e56[DOTW]) begin
			reg_c    = REG_EDGE_BC;
			base_sel = SEL_B;
			dir_sel  = SEL_B;
			n1_c     = VW'(e43);
			den_c    = DENW'(e43) + DENW'(e56);
		end else begin
			reg_c   = REG_FACE;
			is_face = 1'b1;
			n1_c    = vb_s5;
			n2_c    = vc_s5;
			den_c   = DENW'(va_s5) + DENW'(vb_s5) + DENW'(vc_s5);
		end
	end

	logic signed [VW-1:0]   n1_s6, n2_s6;
	logic signed [DENW-1:0] den_s6;
	logic signed [W-1:0]    base_s6 [3];
	logic signed [DW-1:0]   dir1_s6 [3], dir2_s6 [3];
	region_t                reg_s6;
	logic                   degen_s6, use_s6, vld_s6;
	logic                   den_le0;

	assign den_le0 = den_c[DENW-1] || (den_c == '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			n1_s6    <= n1_c;
			n2_s6    <= n2_c;
			den_s6   <= den_c;
			reg_s6   <= reg_c;
			degen_s6 <= is_face && den_le0;
			use_s6   <= !den_le0;
			for (int j = 0; j < 3; j++) begin
				unique case (base_sel)
					SEL_B:   base_s6[j] <= b_s5[j];
					SEL_C:   base_s6[j] <= c_s5[j];
					default: base_s6[j] <= a_s5[j];
				endcase
				unique case (dir_sel)
					SEL_B:   dir1_s6[j] <= bc_s5[j];
					SEL_C:   dir1_s6[j] <= ac_s5[j];
					default: dir1_s6[j] <= ab_s5[j];
				endcase
				dir2_s6[j] <= ac_s5[j];
			end
		end
	end

	// ---------------- stage 7: numerator partial products
	// The weights are cut into four chunks; the lower three are unsigned and the
	// top one carries the sign.
	logic signed [CK:0]     nc1 [4], nc2 [4];
	logic signed [MPW-1:0]  mp_s7 [3][4], mq_s7 [3][4];
	logic signed [DENW-1:0] den_s7;
	logic signed [W-1:0]    base_s7 [3];
	region_t                reg_s7;
	logic                   degen_s7, use_s7, vld_s7;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			nc1[c] = {1'b0, n1_s6[CK*c +: CK]};
			nc2[c] = {1'b0, n2_s6[CK*c +: CK]};
		end
		nc1[3] = {{(CK+1-TW){n1_s6[VW-1]}}, n1_s6[VW-1:3*CK]};
		nc2[3] = {{(CK+1-TW){n2_s6[VW-1]}}, n2_s6[VW-1:3*CK]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				for (int c = 0; c < 4; c++) begin
					mp_s7[j][c] <= MPW'(nc1[c]) * MPW'(dir1_s6[j]);
					mq_s7[j][c] <= MPW'(nc2[c]) * MPW'(dir2_s6[j]);
				end
			end
			den_s7   <= den_s6;
			base_s7  <= base_s6;
			reg_s7   <= reg_s6;
			degen_s7 <= degen_s6;
			use_s7   <= use_s6;
		end
	end

	// ---------------- stage 8: numerator sums
	logic signed [NUMW-1:0] num_c [3];
	logic signed [NUMW-1:0] num_s8 [3];
	logic signed [DENW-1:0] den_s8;
	logic signed [W-1:0]    base_s8 [3];
	region_t                reg_s8;
	logic                   degen_s8, use_s8, vld_s8;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			num_c[j] = '0;
			for (int c = 0; c < 4; c++) begin
				num_c[j] = num_c[j]
					+ ((NUMW'(mp_s7[j][c]) + NUMW'(mq_s7[j][c])) <<< (CK * c));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s8   <= num_c;
			den_s8   <= den_s7;
			base_s8  <= base_s7;
			reg_s8   <= reg_s7;
			degen_s8 <= degen_s7;
			use_s8   <= use_s7;
		end
	end

	// ---------------- divider entry (index 0) and divider chain
	// Rounding to nearest is floor((2*num + den) / (2*den)); the divider
	// works on magnitudes and the sign is restored at the end.
	logic [RW-1:0]       rem_sd  [QW+1][3];
	logic [QW-1:0]       quo_sd  [QW+1][3];
	logic [NW-1:0]       mag_sd  [QW+1][3];
	logic                neg_sd  [QW+1][3];
	logic [D2W-1:0]      dv_sd   [QW+1];
	logic signed [W-1:0] base_sd [QW+1][3];
	region_t             reg_sd  [QW+1];
	logic                degen_sd [QW+1];
	logic                use_sd   [QW+1];
	logic                vld_sd   [QW+1];

	logic signed [NW-1:0] nn [3];
	logic [NW-1:0]        nmag [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			nn[j]   = (NW'(num_s8[j]) <<< 1) + NW'(den_s8);
			nmag[j] = nn[j][NW-1] ? NW'(-nn[j]) : NW'(nn[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				mag_sd[0][j] <= nmag[j];
				neg_sd[0][j] <= nn[j][NW-1];
				rem_sd[0][j] <= RW'(nmag[j][NW-1:QW]);
				quo_sd[0][j] <= '0;
			end
			dv_sd[0]    <= D2W'(den_s8) << 1;
			base_sd[0]  <= base_s8;
			reg_sd[0]   <= reg_s8;
			degen_sd[0] <= degen_s8;
			use_sd[0]   <= use_s8;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [RW-1:0] trial [3];
		logic          fits [3];

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				trial[j] = {rem_sd[k][j][RW-2:0], mag_sd[k][j][QW-1-k]};
				fits[j]  = trial[j] >= RW'(dv_sd[k]);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int j = 0; j < 3; j++) begin
					rem_sd[k+1][j] <= fits[j] ? trial[j] - RW'(dv_sd[k]) : trial[j];
					quo_sd[k+1][j] <= {quo_sd[k][j][QW-2:0], fits[j]};
					mag_sd[k+1][j] <= mag_sd[k][j];
					neg_sd[k+1][j] <= neg_sd[k][j];
				end
				dv_sd[k+1]    <= dv_sd[k];
				base_sd[k+1]  <= base_sd[k];
				reg_sd[k+1]   <= reg_sd[k];
				degen_sd[k+1] <= degen_sd[k];
				use_sd[k+1]   <= use_sd[k];
			end
		end
	end

	// ---------------- output stage: sign, offset, clamp
	logic signed [QW+1:0] qs [3];
	logic signed [SW-1:0] sum [3];
	logic signed [W-1:0]  res [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (neg_sd[QW][j]) begin
				qs[j] = -($signed((QW+2)'(quo_sd[QW][j]))
					+ $signed((QW+2)'(rem_sd[QW][j] != '0)));
			end else begin
				qs[j] = $signed((QW+2)'(quo_sd[QW][j]));
			end
			sum[j] = SW'(base_sd[QW][j]) + SW'(qs[j]);
			if (!use_sd[QW]) begin
				res[j] = base_sd[QW][j];
			end else if (!sum[j][SW-1] && (|sum[j][SW-2:W-1])) begin
				res[j] = {1'b0, {(W-1){1'b1}}};
			end else if (sum[j][SW-1] && !(&sum[j][SW-2:W-1])) begin
				res[j] = {1'b1, {(W-1){1'b0}}};
			end else begin
				res[j] = sum[j][W-1:0];
			end
		end
	end

	logic signed [W-1:0] res_so [3];
	region_t             reg_so;
	logic                degen_so, vld_so;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_so   <= res;
			reg_so   <= reg_sd[QW];
			degen_so <= degen_sd[QW];
		end
	end

	assign nearest_x  = res_so[0];
	assign nearest_y  = res_so[1];
	assign nearest_z  = res_so[2];
	assign region     = reg_so;
	assign degenerate = degen_so;
	assign out_valid  = vld_so;

	// ---------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int k = 0; k <= QW; k++) begin
				vld_sd[k] <= 1'b0;
			end
			vld_so <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_sd[0] <= vld_s8;
			for (int k = 0; k < QW; k++) begin
				vld_sd[k+1] <= vld_sd[k];
			end
			vld_so <= vld_sd[QW];
		end
	end

endmodule
